// ===== rtl/bfsc_pkg.sv =====
package bfsc_pkg;

    // Default sizes handed to the top level parameters.
    localparam int STATE_BYTES_DEF      = 16;
    localparam int FINAL_MIX_ROUNDS_DEF = 4;

    // Byte constants of the mix pass and the key fill.
    localparam logic [7:0] MIX_ADD   = 8'h9E;
    localparam logic [7:0] MIX_XOR   = 8'h37;
    localparam logic [7:0] FILL_BYTE = 8'hAA;

    // Operation codes carried on the input channel.
    localparam logic [2:0] OP_START_KEY  = 3'd0;
    localparam logic [2:0] OP_KEY_BYTE   = 3'd1;
    localparam logic [2:0] OP_FINISH_KEY = 3'd2;
    localparam logic [2:0] OP_ENCRYPT    = 3'd3;
    localparam logic [2:0] OP_DECRYPT    = 3'd4;

    // Commands to the state ring.
    typedef enum logic [1:0] {
        RING_HOLD   = 2'd0,
        RING_FILL   = 2'd1,
        RING_XOR_AT = 2'd2,
        RING_SHIFT  = 2'd3
    } ring_cmd_t;

    typedef struct packed {
        ring_cmd_t  cmd;
        logic [7:0] data;
    } ring_ctrl_t;

    // Function selected in the shared byte unit.
    typedef enum logic {
        UNIT_MIX    = 1'b0,
        UNIT_MUTATE = 1'b1
    } unit_mode_t;

    typedef struct packed {
        unit_mode_t mode;
        logic [7:0] feedback;
    } unit_ctrl_t;

endpackage

// ===== rtl/bfsc_byte_unit.sv =====
module bfsc_byte_unit (
    input  bfsc_pkg::unit_ctrl_t ctrl,
    input  logic [7:0]           index,
    input  logic [7:0]           cur_byte,
    input  logic [7:0]           next_byte,
    input  logic [7:0]           prev_byte,
    output logic [7:0]           new_byte
);

    logic [7:0] mix_xor;
    logic [7:0] mix_sum;
    logic [7:0] mix_out;
    logic [7:0] mut_key;
    logic [7:0] mut_out;

    // Mix step: fold in the rotated neighbor, add and whiten, then fold in the
    // shifted predecessor.
    assign mix_xor = cur_byte ^ {next_byte[4:0], next_byte[7:5]};
    assign mix_sum = mix_xor + bfsc_pkg::MIX_ADD;
    assign mix_out = (mix_sum ^ bfsc_pkg::MIX_XOR) ^ {2'b00, prev_byte[7:2]};

    // Mutate step: mask with the feedback plus position, then add the neighbor.
    assign mut_key = ctrl.feedback + index;
    assign mut_out = (cur_byte ^ mut_key) + next_byte;

    always_comb begin
        unique case (ctrl.mode)
            bfsc_pkg::UNIT_MIX:    new_byte = mix_out;
            bfsc_pkg::UNIT_MUTATE: new_byte = mut_out;
            default:               new_byte = mix_out;
        endcase
    end

endmodule

// ===== rtl/bfsc_state_ring.sv =====
module bfsc_state_ring #(
    parameter int STATE_BYTES = bfsc_pkg::STATE_BYTES_DEF,
    parameter int IDX_W       = $clog2(STATE_BYTES)
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  bfsc_pkg::ring_ctrl_t ctrl,
    input  logic [IDX_W-1:0]     xor_pos,
    input  logic [7:0]           shift_in,
    output logic [7:0]           head_byte,
    output logic [7:0]           second_byte,
    output logic [7:0]           tail_byte
);

    logic [7:0] ring_reg  [STATE_BYTES];
    logic [7:0] ring_next [STATE_BYTES];

    // Next ring contents: hold, fill, XOR one addressed byte, or shift by one with shift_in entering at the tail.
    always_comb begin
        for (int k = 0; k < STATE_BYTES; k++) begin
            ring_next[k] = ring_reg[k];
        end
        unique case (ctrl.cmd)
            bfsc_pkg::RING_HOLD: begin
            end
            bfsc_pkg::RING_FILL: begin
                for (int k = 0; k < STATE_BYTES; k++) begin
                    ring_next[k] = bfsc_pkg::FILL_BYTE;
                end
            end
            bfsc_pkg::RING_XOR_AT: begin
                for (int k = 0; k < STATE_BYTES; k++) begin
                    if (IDX_W'(k) == xor_pos) begin
                        ring_next[k] = ring_reg[k] ^ ctrl.data;
                    end
                end
            end
            bfsc_pkg::RING_SHIFT: begin
                for (int k = 0; k < STATE_BYTES - 1; k++) begin
                    ring_next[k] = ring_reg[k + 1];
                end
                ring_next[STATE_BYTES - 1] = shift_in;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < STATE_BYTES; k++) begin
                ring_reg[k] <= bfsc_pkg::FILL_BYTE;
            end
        end else begin
            for (int k = 0; k < STATE_BYTES; k++) begin
                ring_reg[k] <= ring_next[k];
            end
        end
    end

    assign head_byte   = ring_reg[0];
    assign second_byte = ring_reg[1];
    assign tail_byte   = ring_reg[STATE_BYTES - 1];

endmodule

// ===== rtl/byte_feedback_stream_cipher_unit.sv =====
// Byte feedback stream cipher with a STATE_BYTES-byte state held in a rotating
// ring and updated one byte per cycle by a single shared byte unit. Start key
// and unused operation codes finish in the accept cycle. A key byte runs one
// XOR step and one mix pass, finish key runs FINAL_MIX_ROUNDS mix passes, and
// an encrypt or decrypt beat runs a mutate pass, the wrap rotation and the
// hand-off into the output register; s_ready is low while an operation is in
// progress. The ring moves one byte through the byte unit per cycle. A result
// waiting on the output does not hold up the next input beat, except that a
// data beat finishing while it is still untaken waits in its hand-off cycle.
module byte_feedback_stream_cipher_unit #(
    parameter int STATE_BYTES      = bfsc_pkg::STATE_BYTES_DEF,
    parameter int FINAL_MIX_ROUNDS = bfsc_pkg::FINAL_MIX_ROUNDS_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [2:0] s_operation,
    input  logic [7:0] s_data_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_result_byte
);

    localparam int IDX_W = $clog2(STATE_BYTES);
    localparam int RND_W = (FINAL_MIX_ROUNDS > 1) ? $clog2(FINAL_MIX_ROUNDS) : 1;

    typedef enum logic [5:0] {
        ST_IDLE    = 6'b000001,
        ST_KEY_XOR = 6'b000010,
        ST_MIX     = 6'b000100,
        ST_MUTATE  = 6'b001000,
        ST_WRAP    = 6'b010000,
        ST_DELIVER = 6'b100000
    } seq_state_t;

    seq_state_t       state_reg,  state_next;
    logic [IDX_W-1:0] step_reg,   step_next;
    logic [IDX_W-1:0] pos_reg,    pos_next;
    logic [RND_W-1:0] round_reg,  round_next;
    logic             key_op_reg, key_op_next;
    logic [7:0]       byte_reg,   byte_next;
    logic [7:0]       fb_reg,     fb_next;
    logic [7:0]       res_reg,    res_next;
    logic             out_valid_reg, out_valid_next;
    logic [7:0]       out_byte_reg,  out_byte_next;

    bfsc_pkg::ring_ctrl_t ring_ctrl;
    bfsc_pkg::unit_ctrl_t unit_ctrl;
    logic [7:0]           head_byte;
    logic [7:0]           second_byte;
    logic [7:0]           tail_byte;
    logic [7:0]           unit_byte;
    logic [7:0]           ring_in;
    logic                 in_beat;
    logic                 last_step;
    logic [7:0]           keystream;
    logic [7:0]           data_result;

    assign s_ready   = (state_reg == ST_IDLE);
    assign in_beat   = s_valid && s_ready;
    assign last_step = (step_reg == IDX_W'(STATE_BYTES - 1));

    // Keystream and result of a data beat, taken from the state at accept.
    assign keystream   = head_byte ^ tail_byte;
    assign data_result = s_data_byte ^ keystream;

    // Shared byte unit: the current byte sits at the ring head, its successor
    // next to it, and the last written byte at the ring tail.
    assign unit_ctrl.mode     = (state_reg == ST_MIX) ? bfsc_pkg::UNIT_MIX
                                                      : bfsc_pkg::UNIT_MUTATE;
    assign unit_ctrl.feedback = fb_reg;

    bfsc_byte_unit u_byte_unit (
        .ctrl      (unit_ctrl),
        .index     (8'(step_reg)),
        .cur_byte  (head_byte),
        .next_byte (second_byte),
        .prev_byte (tail_byte),
        .new_byte  (unit_byte)
    );

    // The wrap cycle rotates once more and folds the feedback into the head.
    assign ring_in = (state_reg == ST_WRAP) ? (head_byte ^ fb_reg) : unit_byte;

    bfsc_state_ring #(
        .STATE_BYTES (STATE_BYTES),
        .IDX_W       (IDX_W)
    ) u_state_ring (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .ctrl        (ring_ctrl),
        .xor_pos     (pos_reg),
        .shift_in    (ring_in),
        .head_byte   (head_byte),
        .second_byte (second_byte),
        .tail_byte   (tail_byte)
    );

    // Sequencer.
    always_comb begin
        state_next     = state_reg;
        step_next      = step_reg;
        pos_next       = pos_reg;
        round_next     = round_reg;
        key_op_next    = key_op_reg;
        byte_next      = byte_reg;
        fb_next        = fb_reg;
        res_next       = res_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_byte_next  = out_byte_reg;
        ring_ctrl.cmd  = bfsc_pkg::RING_HOLD;
        ring_ctrl.data = byte_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_beat) begin
                    unique case (s_operation)
                        bfsc_pkg::OP_START_KEY: begin
                            ring_ctrl.cmd = bfsc_pkg::RING_FILL;
                            pos_next      = '0;
                        end
                        bfsc_pkg::OP_KEY_BYTE: begin
                            byte_next   = s_data_byte;
                            round_next  = '0;
                            key_op_next = 1'b1;
                            state_next  = ST_KEY_XOR;
                        end
                        bfsc_pkg::OP_FINISH_KEY: begin
                            if (FINAL_MIX_ROUNDS > 0) begin
                                round_next  = RND_W'(FINAL_MIX_ROUNDS - 1);
                                step_next   = '0;
                                key_op_next = 1'b0;
                                state_next  = ST_MIX;
                            end
                        end
                        bfsc_pkg::OP_ENCRYPT, bfsc_pkg::OP_DECRYPT: begin
                            res_next   = data_result;
                            fb_next    = (s_operation == bfsc_pkg::OP_ENCRYPT) ? data_result
                                                                               : s_data_byte;
                            step_next  = '0;
                            state_next = ST_MUTATE;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_KEY_XOR: begin
                ring_ctrl.cmd = bfsc_pkg::RING_XOR_AT;
                step_next     = '0;
                state_next    = ST_MIX;
            end
            ST_MIX: begin
                ring_ctrl.cmd = bfsc_pkg::RING_SHIFT;
                step_next     = step_reg + IDX_W'(1);
                if (last_step) begin
                    step_next = '0;
                    if (round_reg == '0) begin
                        if (key_op_reg) begin
                            pos_next = (pos_reg == IDX_W'(STATE_BYTES - 1)) ? '0
                                                                             : pos_reg + IDX_W'(1);
                        end
                        state_next = ST_IDLE;
                    end else begin
                        round_next = round_reg - RND_W'(1);
                    end
                end
            end
            ST_MUTATE: begin
                ring_ctrl.cmd = bfsc_pkg::RING_SHIFT;
                step_next     = step_reg + IDX_W'(1);
                if (last_step) begin
                    step_next  = '0;
                    state_next = ST_WRAP;
                end
            end
            ST_WRAP: begin
                ring_ctrl.cmd = bfsc_pkg::RING_SHIFT;
                state_next    = ST_DELIVER;
            end
            ST_DELIVER: begin
                // Hand the result over once the output register is free.
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    out_byte_next  = res_reg;
                    state_next     = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            pos_reg       <= '0;
            round_reg     <= '0;
            key_op_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            pos_reg       <= pos_next;
            round_reg     <= round_next;
            key_op_reg    <= key_op_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge aclk) begin
        byte_reg     <= byte_next;
        fb_reg       <= fb_next;
        res_reg      <= res_next;
        out_byte_reg <= out_byte_next;
    end

    assign m_valid       = out_valid_reg;
    assign m_result_byte = out_byte_reg;

endmodule
